// File: hw/rtl/twfr_pkg.sv
// Shared types and constants for the two-window frequency replacement core.
package twfr_pkg;

    localparam int ID_W    = 16;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CFG_W-1:0]   BLOCKS_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_READ       = 2'd0,
        CMD_WRITE      = 2'd1,
        CMD_WINDOW_END = 2'd2,
        CMD_FIND       = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t            cmd;
        logic [ID_W-1:0] file_id;
        logic [ID_W-1:0] seg_id;
    } job_t;

    typedef struct packed {
        logic [COUNT_W-1:0] prev;
        logic [COUNT_W-1:0] cur;
        logic [ID_W-1:0]    seg_id;
        logic [ID_W-1:0]    file_id;
    } entry_t;

endpackage

// File: hw/rtl/two_window_frequency_replacement_core.sv
// Top level of the two-window frequency replacement core.
//
// Holds up to CAPACITY blocks (file id, segment id, current and previous
// window hit counts) in insertion order in one RAM with a registered read
// port. Every beat yields exactly one result beat. A front queue of two
// beats takes input while the back end works. The back end visits the
// held entries one at a time through the RAM: a read or find stops at
// the first match, a window end moves each current count to previous,
// and a write with no room picks the victim with the lowest summed counts
// (the earliest on a tie), shifts the later entries down and appends the
// new block last. The user must write blocks_in_use through cfg_wr_en
// only while the core is idle; the core itself does not enforce this.
// Zero acts as one and values above CAPACITY act as CAPACITY.
// No clearing pass runs after reset.
module two_window_frequency_replacement_core
    import twfr_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,   // blocks_in_use
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,       // file_id[15:0], seg_id[31:16]
    input  logic [1:0]       s_tuser,       // cmd[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,       // evicted_file_id[15:0], evicted_seg_id[31:16]
    output logic [1:0]       m_tuser        // found[0], evicted[1]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0] blocks_reg, blocks_next;
    logic [LW-1:0]    blocks_ext, limit;
    logic             job_valid, job_pop;
    job_t             job;

    assign blocks_next = cfg_wr_en ? cfg_wr_data : blocks_reg;
    assign blocks_ext  = LW'(blocks_reg);

    always_comb
    begin
        if (blocks_reg == '0)
        begin
            limit = LW'(1);
        end
        else if (blocks_ext > LW'(CAPACITY))
        begin
            limit = LW'(CAPACITY);
        end
        else
        begin
            limit = blocks_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_reg <= BLOCKS_RESET;
        end
        else
        begin
            blocks_reg <= blocks_next;
        end
    end

    twfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job)
    );

    twfr_back #(
        .CAPACITY (CAPACITY),
        .LW       (LW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: hw/rtl/twfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module twfr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/twfr_front.sv
// Front end: accept input beats, classify them and queue them for the back end.
module twfr_front
    import twfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        job_valid,
    input  logic        job_pop,
    output job_t        job
);

    job_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    job_t       in_job;

    always_comb
    begin
        in_job.cmd     = cmd_t'(s_tuser);
        in_job.file_id = s_tdata[ID_W-1:0];
        in_job.seg_id  = s_tdata[2*ID_W-1:ID_W];
    end

    assign s_tready  = (count_reg != 2'd2);
    assign job_valid = (count_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = job_pop && job_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/twfr_back.sv
// Back end: sequence lookups, window ends, evictions and appends over the block RAM.
module twfr_back
    import twfr_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int LW       = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [LW-1:0] limit,
    input  logic          job_valid,
    output logic          job_pop,
    input  job_t          job,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,
    output logic [1:0]    m_tuser
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = $bits(entry_t);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_RD      = 7'b0000010,
        S_CHK     = 7'b0000100,
        S_MOVE_RD = 7'b0001000,
        S_MOVE_WR = 7'b0010000,
        S_APPEND  = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [ID_W-1:0]     file_reg, file_next;
    logic [ID_W-1:0]     seg_reg, seg_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       occ_reg, occ_next;
    logic [COUNT_W:0]    best_w_reg, best_w_next;
    logic [CW-1:0]       best_idx_reg, best_idx_next;
    logic [ID_W-1:0]     ev_file_reg, ev_file_next;
    logic [ID_W-1:0]     ev_seg_reg, ev_seg_next;
    logic                evict_reg, evict_next;
    logic                found_reg, found_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_data_reg, out_data_next;
    logic [1:0]          out_user_reg, out_user_next;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    entry_t              ram_wdata, rd_entry;
    logic [EW-1:0]       ram_rdata;
    logic [CW-1:0]       idx_inc, sel_idx;
    logic [COUNT_W:0]    w_sum;
    logic                take;

    twfr_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);
    assign idx_inc  = idx_reg + CW'(1);
    assign w_sum    = {1'b0, rd_entry.cur} + {1'b0, rd_entry.prev};
    assign take     = (idx_reg == '0) || (w_sum < best_w_reg);
    assign sel_idx  = take ? idx_reg : best_idx_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        file_next      = file_reg;
        seg_next       = seg_reg;
        idx_next       = idx_reg;
        occ_next       = occ_reg;
        best_w_next    = best_w_reg;
        best_idx_next  = best_idx_reg;
        ev_file_next   = ev_file_reg;
        ev_seg_next    = ev_seg_reg;
        evict_next     = evict_reg;
        found_next     = found_reg;
        out_valid_next = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = idx_reg[AW-1:0];
        ram_raddr      = idx_reg[AW-1:0];
        ram_wdata      = rd_entry;
        job_pop        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop      = 1'b1;
                    cmd_next     = job.cmd;
                    file_next    = job.file_id;
                    seg_next     = job.seg_id;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    evict_next   = 1'b0;
                    ev_file_next = '0;
                    ev_seg_next  = '0;
                    unique case (job.cmd) inside
                        CMD_READ, CMD_FIND, CMD_WINDOW_END:
                            state_next = (occ_reg == '0) ? S_DONE : S_RD;
                        default:
                            state_next = (LW'(occ_reg) >= limit) ? S_RD : S_APPEND;
                    endcase
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                unique case (cmd_reg) inside
                    CMD_READ, CMD_FIND:
                    begin
                        if (rd_entry.file_id == file_reg && rd_entry.seg_id == seg_reg)
                        begin
                            found_next = 1'b1;
                            if (cmd_reg == CMD_READ && rd_entry.cur != COUNT_MAX)
                            begin
                                ram_we        = 1'b1;
                                ram_wdata.cur = rd_entry.cur + COUNT_W'(1);
                            end
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            state_next = (idx_inc == occ_reg) ? S_DONE : S_RD;
                        end
                    end
                    CMD_WINDOW_END:
                    begin
                        ram_we         = 1'b1;
                        ram_wdata.prev = rd_entry.cur;
                        ram_wdata.cur  = '0;
                        idx_next       = idx_inc;
                        state_next     = (idx_inc == occ_reg) ? S_DONE : S_RD;
                    end
                    default:
                    begin
                        if (take)
                        begin
                            best_w_next   = w_sum;
                            best_idx_next = idx_reg;
                            ev_file_next  = rd_entry.file_id;
                            ev_seg_next   = rd_entry.seg_id;
                        end
                        if (idx_inc == occ_reg)
                        begin
                            evict_next = 1'b1;
                            idx_next   = sel_idx;
                            state_next = ((sel_idx + CW'(1)) == occ_reg) ? S_APPEND : S_MOVE_RD;
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            state_next = S_RD;
                        end
                    end
                endcase
            end
            S_MOVE_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_inc[AW-1:0];
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                ram_we     = 1'b1;
                idx_next   = idx_inc;
                state_next = ((idx_inc + CW'(1)) == occ_reg) ? S_APPEND : S_MOVE_RD;
            end
            S_APPEND:
            begin
                ram_we            = 1'b1;
                ram_wdata.file_id = file_reg;
                ram_wdata.seg_id  = seg_reg;
                ram_wdata.cur     = '0;
                ram_wdata.prev    = '0;
                if (evict_reg)
                begin
                    ram_waddr = AW'(occ_reg - CW'(1));
                end
                else
                begin
                    ram_waddr = occ_reg[AW-1:0];
                    occ_next  = occ_reg + CW'(1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {ev_seg_reg, ev_file_reg};
                    out_user_next  = {evict_reg, found_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        file_reg     <= file_next;
        seg_reg      <= seg_next;
        idx_reg      <= idx_next;
        best_w_reg   <= best_w_next;
        best_idx_reg <= best_idx_next;
        ev_file_reg  <= ev_file_next;
        ev_seg_reg   <= ev_seg_next;
        evict_reg    <= evict_next;
        found_reg    <= found_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sim/two_window_frequency_replacement_core_tb.sv
// Testbench for the two-window frequency replacement core: scoreboard and stimulus.
`timescale 1ns / 100ps

module two_window_frequency_replacement_core_tb;
    import twfr_pkg::*;

    localparam int CAP = 64;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic        found;
        logic        evicted;
        logic [15:0] ev_file;
        logic [15:0] ev_seg;
    } verdict_t;

    class replacement_scoreboard;
        logic [15:0] blk_file[CAP];
        logic [15:0] blk_seg[CAP];
        logic [15:0] cnt_cur[CAP];
        logic [15:0] cnt_prev[CAP];
        int          held;
        logic [6:0]  size_reg;
        verdict_t    pending[$];
        int          errors;

        function new();
            held = 0;
            size_reg = BLOCKS_RESET;
            errors = 0;
        endfunction

        function int limit();
            int lim;
            lim = size_reg;
            if (lim == 0) lim = 1;
            if (lim > CAP) lim = CAP;
            return lim;
        endfunction

        function void note_job(cmd_t cmd, logic [15:0] f, logic [15:0] s);
            verdict_t v;
            int k;
            int best;
            int bw;
            int w;
            v = '0;
            if (cmd == CMD_READ || cmd == CMD_FIND) begin
                k = 0;
                while (k < held && !(blk_file[k] == f && blk_seg[k] == s)) k++;
                if (k < held) begin
                    v.found = 1'b1;
                    if (cmd == CMD_READ && cnt_cur[k] != COUNT_MAX) cnt_cur[k]++;
                end
            end else if (cmd == CMD_WINDOW_END) begin
                for (k = 0; k < held; k++) begin
                    cnt_prev[k] = cnt_cur[k];
                    cnt_cur[k] = '0;
                end
            end else begin
                if (held >= limit() && held > 0) begin
                    best = 0;
                    bw = cnt_cur[0] + cnt_prev[0];
                    for (k = 1; k < held; k++) begin
                        w = cnt_cur[k] + cnt_prev[k];
                        if (w < bw) begin
                            bw = w;
                            best = k;
                        end
                    end
                    v.evicted = 1'b1;
                    v.ev_file = blk_file[best];
                    v.ev_seg = blk_seg[best];
                    for (k = best; k + 1 < held; k++) begin
                        blk_file[k] = blk_file[k+1];
                        blk_seg[k] = blk_seg[k+1];
                        cnt_cur[k] = cnt_cur[k+1];
                        cnt_prev[k] = cnt_prev[k+1];
                    end
                    held--;
                end
                if (held < CAP) begin
                    blk_file[held] = f;
                    blk_seg[held] = s;
                    cnt_cur[held] = '0;
                    cnt_prev[held] = '0;
                    held++;
                end
            end
            pending = {pending, v};
        endfunction

        function void check_result(verdict_t got);
            verdict_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.found !== exp.found) begin
                $display("%0t: found expected %b actual %b", $time, exp.found, got.found);
                errors++;
            end
            if (got.evicted !== exp.evicted) begin
                $display("%0t: evicted expected %b actual %b", $time, exp.evicted, got.evicted);
                errors++;
            end
            if (got.ev_file !== exp.ev_file) begin
                $display("%0t: evicted_file_id expected %h actual %h", $time, exp.ev_file,
                         got.ev_file);
                errors++;
            end
            if (got.ev_seg !== exp.ev_seg) begin
                $display("%0t: evicted_seg_id expected %h actual %h", $time, exp.ev_seg,
                         got.ev_seg);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    replacement_scoreboard sb;
    int  cycles;
    bit  calm;
    bit  hold_sink;
    logic [15:0] pool_f[8];
    logic [15:0] pool_s[8];

    two_window_frequency_replacement_core #(.CAPACITY(CAP)) uut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("two_window_frequency_replacement_core_tb NOT OK");
            $finish;
        end
    end

    // sink: accept results, stall in bursts
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result({m_tuser[0], m_tuser[1], m_tdata[15:0], m_tdata[31:16]});
            if (hold_sink)
                m_tready <= 1'b0;
            else if (!calm && gap == 0 && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 4);
                m_tready <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                m_tready <= (gap == 0);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send(cmd_t cmd, logic [15:0] f, logic [15:0] s);
        int idle;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            idle = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {s, f};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_job(cmd, f, s);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_size(logic [6:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.size_reg = val;
    endtask

    task automatic random_item();
        int r;
        int p;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, 7);
        if (r < 35) send(CMD_READ, pool_f[p], pool_s[p]);
        else if (r < 65) send(CMD_WRITE, pool_f[p], pool_s[p]);
        else if (r < 72) send(CMD_WINDOW_END, 16'($urandom), 16'($urandom));
        else if (r < 88) send(CMD_FIND, pool_f[p], pool_s[p]);
        else send(cmd_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        calm = 1'b0;
        hold_sink = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_READ;
        for (int i = 0; i < 8; i++)
        begin
            pool_f[i] = 16'($urandom);
            pool_s[i] = 16'($urandom);
        end
        pool_f[0] = 16'hFFFF; pool_s[0] = 16'hFFFF;
        pool_f[1] = 16'h0000; pool_s[1] = 16'h0000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: miss on empty, extremes, duplicates, small size, zero size
        send(CMD_READ, 16'h0000, 16'h0000);
        send(CMD_FIND, 16'hFFFF, 16'hFFFF);
        send(CMD_WINDOW_END, 16'h0000, 16'h0000);
        set_size(7'd2);
        send(CMD_WRITE, 16'hFFFF, 16'hFFFF);
        send(CMD_WRITE, 16'h0000, 16'h0000);
        send(CMD_READ, 16'hFFFF, 16'hFFFF);
        send(CMD_WRITE, 16'h1234, 16'hABCD);
        send(CMD_WRITE, 16'h1234, 16'hABCD);
        send(CMD_READ, 16'h1234, 16'hABCD);
        send(CMD_FIND, 16'h1234, 16'hABCD);
        send(CMD_WINDOW_END, 16'hFFFF, 16'hFFFF);
        send(CMD_WRITE, 16'h5555, 16'hAAAA);
        send(CMD_READ, 16'h0000, 16'h0000);
        set_size(7'd0);
        send(CMD_WRITE, 16'hAAAA, 16'h5555);
        send(CMD_WRITE, 16'h0F0F, 16'hF0F0);
        set_size(7'd127);
        send(CMD_WRITE, 16'h0001, 16'h8000);

        // receiver holds off while the sender keeps offering
        fork
            begin
                hold_sink = 1'b1;
                repeat (400) @(posedge clk);
                hold_sink = 1'b0;
            end
            repeat (12) random_item();
        join

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_size(7'd64);
                1: set_size(7'd1);
                2: set_size(7'($urandom_range(2, 8)));
                3: set_size(7'd100);
                4: set_size(7'($urandom_range(3, 16)));
                default: set_size(7'd4);
            endcase
            if (ph == 5) calm = 1'b1;
            for (int n = 0; n < 180; n++) random_item();
        end

        // closing write and find on a small buffer
        set_size(7'd2);
        send(CMD_WRITE, 16'hBEEF, 16'hCAFE);
        send(CMD_FIND, 16'hBEEF, 16'hCAFE);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("two_window_frequency_replacement_core_tb OK");
        else
            $display("two_window_frequency_replacement_core_tb NOT OK");
        $finish;
    end
endmodule
